### hw/rtl/msde_pkg.sv
// ----------------------------------------------------------------------------
// msde_pkg
// types and codes shared by the minimum-tracking stack and its cells
// ----------------------------------------------------------------------------
package msde_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned DiffW  = ValueW + 1;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [DiffW-1:0]  diff_t;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // shift command broadcast along the row of cells
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

### hw/rtl/msde_cell.sv
// ----------------------------------------------------------------------------
// msde_cell
// one stack slot: holds a stored difference, shifts down on push, up on pop
// ----------------------------------------------------------------------------
module msde_cell import msde_pkg::*; (
  input  logic   clk_i,
  input  shift_t shift_i,
  input  diff_t  above_i,
  input  diff_t  below_i,
  output diff_t  diff_o
);

  diff_t diff_q, diff_d;

  always_comb begin
    diff_d = diff_q;
    if (shift_i.push) begin
      diff_d = above_i;
    end else if (shift_i.pop) begin
      diff_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  assign diff_o = diff_q;

endmodule

### hw/rtl/min_stack_diff_encoded.sv
// ----------------------------------------------------------------------------
// min_stack_diff_encoded
// bounded stack of signed 32-bit values that reports its minimum after every
// push or pop; entries are kept as 33-bit differences in a row of shift cells
// ----------------------------------------------------------------------------
// One transaction is taken per cycle while out_ready_i does not hold the
// output. The stack itself is a row of STACK_DEPTH cells that all shift down
// on a push and up on a pop, so the top entry always sits in the first cell
// and each operation is one subtract on the way in. After the state is
// registered, a transaction's result is loaded into an output register that
// is rebuilt from the stored minimum and the first cell with one add; the
// next transaction is accepted in the same cycle as long as that register
// can be refilled. A push to a full stack or a pop from an empty one leaves
// the state unchanged and is flagged in status_o. Cell contents are not
// cleared by reset; only busy, valid, count, minimum and status are.
module min_stack_diff_encoded import msde_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic signed [31:0]               push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               top_value_o,
  output logic signed [31:0]               min_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] depth_o,
  output logic                             is_empty_o,
  output logic [1:0]                       status_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  logic            in_fire, out_load;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  value_t          min_q, min_d;
  status_e         status_q, status_d;
  shift_t          shift;
  diff_t           push_diff, sub_diff;
  diff_t           cell_diff [STACK_DEPTH];

  value_t          top_q, top_d, omin_q, omin_d;
  logic [CntW-1:0] depth_q;
  logic            empty_q;
  status_e         ostatus_q;
  diff_t           top_sum;

  assign out_load   = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // state update
  always_comb begin
    shift     = '0;
    cnt_d     = cnt_q;
    min_d     = min_q;
    status_d  = status_q;
    push_diff = '0;
    sub_diff  = diff_t'({push_value_i[31], push_value_i}) - diff_t'({min_q[31], min_q});
    if (in_fire) begin
      status_d = STATUS_OK;
      if (kind_e'(kind_i) == KIND_PUSH) begin
        if (cnt_q == CntFull) begin
          status_d = STATUS_FULL;
        end else begin
          shift.push = 1'b1;
          cnt_d      = cnt_q + CntW'(1);
          if (cnt_q == '0) begin
            min_d = push_value_i;
          end else begin
            push_diff = sub_diff;
            if (sub_diff[DiffW-1]) begin
              min_d = push_value_i;
            end
          end
        end
      end else begin
        if (cnt_q == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          shift.pop = 1'b1;
          cnt_d     = cnt_q - CntW'(1);
          if (cell_diff[0][DiffW-1]) begin
            min_d = value_t'(diff_t'({min_q[31], min_q}) - cell_diff[0]);
          end
        end
      end
    end
  end

  // row of cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    diff_t above, below;
    if (i == 0) begin : g_first
      assign above = push_diff;
    end else begin : g_mid
      assign above = cell_diff[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_diff[i+1];
    end
    msde_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .diff_o  (cell_diff[i])
    );
  end

  // result build from registered state
  assign top_sum = diff_t'({min_q[31], min_q}) + cell_diff[0];

  always_comb begin
    top_d  = '0;
    omin_d = '0;
    if (cnt_q != '0) begin
      omin_d = min_q;
      if (!cell_diff[0][DiffW-1] && (cell_diff[0] != '0)) begin
        top_d = value_t'(top_sum);
      end else begin
        top_d = min_q;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
    end
    if (in_fire) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      min_q       <= '0;
      status_q    <= STATUS_OK;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      min_q       <= min_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      top_q     <= top_d;
      omin_q    <= omin_d;
      depth_q   <= cnt_q;
      empty_q   <= (cnt_q == '0);
      ostatus_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign min_value_o = omin_q;
  assign depth_o     = depth_q;
  assign is_empty_o  = empty_q;
  assign status_o    = ostatus_q;

endmodule
